[src/met_pkg.sv]
// met_pkg: shared widths, register indexes, config struct, sequencer states
// and the saturation helper for the mandelbrot escape-time engine.
// No dependencies.
package met_pkg;

  // field widths
  localparam int PIX_W      = 9;
  localparam int CNT_W      = 12;
  localparam int Q_W        = 32;
  localparam int STEP_W     = 31;
  localparam int FRAC_BITS  = 28;
  localparam int PROD_W     = 2 * Q_W;
  localparam int WIDE_W     = PROD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // default image size
  localparam int IMAGE_WIDTH  = 512;
  localparam int IMAGE_HEIGHT = 512;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_RE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;

  // register reset values
  localparam logic [STEP_W-1:0] STEP_RE_RST  = 31'd1966080;
  localparam logic [STEP_W-1:0] STEP_IM_RST  = 31'd1310720;
  localparam logic [CNT_W-1:0]  MAX_ITER_RST = 12'd50;

  // |z|^2 bound: 4.0 in Q8.56
  localparam logic [WIDE_W-1:0] ESC_LIMIT = WIDE_W'(1) << (2 * FRAC_BITS + 2);

  // saturation bounds of Q4.28 held in the wide format
  localparam logic signed [WIDE_W-1:0] WIDE_MAX = 65'sd2147483647;
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = -65'sd2147483648;
  localparam logic signed [Q_W-1:0]    Q_MAX    = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0]    Q_MIN    = 32'sh8000_0000;

  typedef struct packed {
    logic [STEP_W-1:0]     step_re;
    logic [STEP_W-1:0]     step_im;
    logic signed [Q_W-1:0] center_re;
    logic signed [Q_W-1:0] center_im;
    logic [CNT_W-1:0]      max_iterations;
  } met_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_CMAP,
    ST_MUL,
    ST_STEP,
    ST_DONE
  } met_state_t;

  // clamp a wide signed value to Q4.28
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > WIDE_MAX) begin
      r = Q_MAX;
    end else if (v < WIDE_MIN) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/met_ifs.sv]
// met_ifs: valid/ready channel interfaces for pixel input, result output and
// configuration writes. Depends on met_pkg for field widths.
interface met_pix_if;
  logic                       valid;
  logic                       ready;
  logic [met_pkg::PIX_W-1:0]  pixel_x;
  logic [met_pkg::PIX_W-1:0]  pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface met_res_if;
  logic                       valid;
  logic                       ready;
  logic [met_pkg::PIX_W-1:0]  out_x;
  logic [met_pkg::PIX_W-1:0]  out_y;
  logic [met_pkg::CNT_W-1:0]  iteration_count;
  modport source (output valid, out_x, out_y, iteration_count, input ready);
  modport sink (input valid, out_x, out_y, iteration_count, output ready);
endinterface

interface met_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [met_pkg::CFG_IDX_W-1:0]   index;
  logic [met_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/mandelbrot_escape_time.sv]
// Mandelbrot escape-time engine, one pixel at a time. A pixel beat maps the
// pixel to c in Q4.28 and iterates z = z*z + c from zero; the result beat
// echoes the pixel and gives the iteration count. From its accept to the
// next possible accept a pixel passes MAP and CMAP for the mapping, a MUL
// then STEP pair (multiply, then update) through the shared multiply unit
// per z step plus one more such pair for the final escape or limit test,
// DONE to load the output register, and IDLE, in which the next pixel
// is taken. The load waits while the output register still holds an earlier
// result. Pixel ready is low while a pixel is being worked; a finished result
// waits in its own output register, so a new pixel can be taken before the
// previous result is collected. Configuration writes are always ready and
// should only be issued while the engine is idle.
// Depends on met_pkg, met_ifs, met_cfg_regs and met_zunit.
module mandelbrot_escape_time #(
  parameter int IMAGE_WIDTH  = met_pkg::IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = met_pkg::IMAGE_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  met_pix_if.sink   pix,
  met_res_if.source res,
  met_cfg_if.sink   cfg
);

  localparam int PW     = met_pkg::PIX_W;
  localparam int QW     = met_pkg::Q_W;
  localparam int CW     = met_pkg::CNT_W;
  localparam int HalfX  = IMAGE_WIDTH / 2;
  localparam int HalfY  = IMAGE_HEIGHT / 2;
  localparam int HalfXW = $clog2(HalfX + 1);
  localparam int HalfYW = $clog2(HalfY + 1);
  localparam int OffXW  = ((HalfXW > PW) ? HalfXW : PW) + 1;
  localparam int OffYW  = ((HalfYW > PW) ? HalfYW : PW) + 1;

  met_pkg::met_cfg_t   regs;
  met_pkg::met_state_t state, state_next;

  logic [PW-1:0]        px, py;
  logic signed [QW-1:0] c_re, c_im, z_re, z_im;
  logic [CW-1:0]        n;
  logic signed [OffXW-1:0] off_x;
  logic signed [OffYW-1:0] off_y;
  logic signed [QW-1:0] map_re, map_im, nr, ni;
  logic                 esc, iter_done, sel_map, out_load, accept;

  // configuration registers
  met_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // signed offsets from the image centre
  assign off_x = signed'(OffXW'(px)) - signed'(OffXW'(HalfX));
  assign off_y = signed'(OffYW'(py)) - signed'(OffYW'(HalfY));

  // shared multiply unit
  met_zunit u_zunit (
    .clk     (clk),
    .sel_map (sel_map),
    .off_x   (QW'(off_x)),
    .off_y   (QW'(off_y)),
    .cfg     (regs),
    .z_re    (z_re),
    .z_im    (z_im),
    .c_re    (c_re),
    .c_im    (c_im),
    .map_re  (map_re),
    .map_im  (map_im),
    .nr      (nr),
    .ni      (ni),
    .esc     (esc)
  );

  assign iter_done = esc || (n >= regs.max_iterations);
  assign accept    = pix.valid && pix.ready;

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      met_pkg::ST_IDLE: if (pix.valid) state_next = met_pkg::ST_MAP;
      met_pkg::ST_MAP:  state_next = met_pkg::ST_CMAP;
      met_pkg::ST_CMAP: state_next = met_pkg::ST_MUL;
      met_pkg::ST_MUL:  state_next = met_pkg::ST_STEP;
      met_pkg::ST_STEP: state_next = iter_done ? met_pkg::ST_DONE : met_pkg::ST_MUL;
      met_pkg::ST_DONE: if (!res.valid || res.ready) state_next = met_pkg::ST_IDLE;
      default:          state_next = met_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pix.ready = 1'b0;
    sel_map   = 1'b0;
    out_load  = 1'b0;
    case (state)
      met_pkg::ST_IDLE: pix.ready = 1'b1;
      met_pkg::ST_MAP:  sel_map   = 1'b1;
      met_pkg::ST_DONE: out_load  = !res.valid || res.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= met_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pixel capture, c and z registers, iteration count
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= pix.pixel_x;
      py <= pix.pixel_y;
    end
    if (state == met_pkg::ST_CMAP) begin
      c_re <= map_re;
      c_im <= map_im;
      z_re <= '0;
      z_im <= '0;
      n    <= '0;
    end else if (state == met_pkg::ST_STEP && !iter_done) begin
      z_re <= nr;
      z_im <= ni;
      n    <= n + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.out_x           <= px;
      res.out_y           <= py;
      res.iteration_count <= n;
    end
  end

endmodule

[src/met_cfg_regs.sv]
// met_cfg_regs: configuration register file, written one beat at a time.
// Depends on met_pkg and met_cfg_if.
module met_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  met_cfg_if.sink           cfg,
  output met_pkg::met_cfg_t regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.step_re        <= met_pkg::STEP_RE_RST;
      regs.step_im        <= met_pkg::STEP_IM_RST;
      regs.center_re      <= '0;
      regs.center_im      <= '0;
      regs.max_iterations <= met_pkg::MAX_ITER_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        met_pkg::CFG_STEP_RE:   regs.step_re        <= cfg.data[met_pkg::STEP_W-1:0];
        met_pkg::CFG_STEP_IM:   regs.step_im        <= cfg.data[met_pkg::STEP_W-1:0];
        met_pkg::CFG_CENTER_RE: regs.center_re      <= signed'(cfg.data[met_pkg::Q_W-1:0]);
        met_pkg::CFG_CENTER_IM: regs.center_im      <= signed'(cfg.data[met_pkg::Q_W-1:0]);
        met_pkg::CFG_MAX_ITER:  regs.max_iterations <= cfg.data[met_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/met_zunit.sv]
// met_zunit: shared multiply unit with registered products, used for the
// pixel-to-point mapping and for every z*z+c step. Depends on met_pkg.
module met_zunit (
  input  logic                               clk,
  input  logic                               sel_map,
  input  logic signed [met_pkg::Q_W-1:0]     off_x,
  input  logic signed [met_pkg::Q_W-1:0]     off_y,
  input  met_pkg::met_cfg_t                  cfg,
  input  logic signed [met_pkg::Q_W-1:0]     z_re,
  input  logic signed [met_pkg::Q_W-1:0]     z_im,
  input  logic signed [met_pkg::Q_W-1:0]     c_re,
  input  logic signed [met_pkg::Q_W-1:0]     c_im,
  output logic signed [met_pkg::Q_W-1:0]     map_re,
  output logic signed [met_pkg::Q_W-1:0]     map_im,
  output logic signed [met_pkg::Q_W-1:0]     nr,
  output logic signed [met_pkg::Q_W-1:0]     ni,
  output logic                               esc
);

  localparam int QW = met_pkg::Q_W;
  localparam int PW = met_pkg::PROD_W;
  localparam int WW = met_pkg::WIDE_W;

  logic signed [QW-1:0] a0, b0, a1, b1;
  logic signed [PW-1:0] p0, p1, p2;
  logic signed [WW-1:0] diff;
  logic [WW-1:0]        mag;

  // operand select: offset*step while mapping, re*re / im*im otherwise
  always_comb begin
    a0 = sel_map ? off_x : z_re;
    b0 = sel_map ? signed'({1'b0, cfg.step_re}) : z_re;
    a1 = sel_map ? off_y : z_im;
    b1 = sel_map ? signed'({1'b0, cfg.step_im}) : z_im;
  end

  // product registers
  always_ff @(posedge clk) begin
    p0 <= a0 * b0;
    p1 <= a1 * b1;
    p2 <= z_re * z_im;
  end

  // mapped point: product plus centre, clamped
  assign map_re = met_pkg::sat_q(WW'(p0) + WW'(cfg.center_re));
  assign map_im = met_pkg::sat_q(WW'(p1) + WW'(cfg.center_im));

  // escape test on exact Q8.56 magnitude
  assign mag = WW'($unsigned(p0)) + WW'($unsigned(p1));
  assign esc = (mag >= met_pkg::ESC_LIMIT);

  // next iterate, flooring shifts then clamp
  assign diff = WW'(p0) - WW'(p1);
  assign nr   = met_pkg::sat_q((diff >>> met_pkg::FRAC_BITS) + WW'(c_re));
  assign ni   = met_pkg::sat_q((WW'(p2) >>> (met_pkg::FRAC_BITS - 1)) + WW'(c_im));

endmodule

[src/met_checker.sv]
// met_checker: port-level checks for the escape-time engine, bound to the
// top level. Depends on met_pkg.
module met_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            pix_valid,
  input logic                            pix_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [met_pkg::PIX_W-1:0]       out_x,
  input logic [met_pkg::PIX_W-1:0]       out_y,
  input logic [met_pkg::CNT_W-1:0]       iteration_count,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [met_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [met_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [met_pkg::CNT_W-1:0] lim;
  logic [1:0]                pending;
  logic                      in_beat, out_beat;

  assign in_beat  = pix_valid && pix_ready;
  assign out_beat = res_valid && res_ready;

  // shadow of the iteration limit
  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= met_pkg::MAX_ITER_RST;
    end else if (cfg_valid && cfg_ready && cfg_index == met_pkg::CFG_MAX_ITER) begin
      lim <= cfg_data[met_pkg::CNT_W-1:0];
    end
  end

  // pixels accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_beat) - 2'(out_beat);
    end
  end

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_x) && $stable(out_y)
      && $stable(iteration_count))
    else $error("result changed while stalled");

  // one pixel in the engine at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !pix_ready)
    else $error("pixel taken while engine busy");

  // count never exceeds the limit
  a_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> iteration_count <= lim)
    else $error("iteration count above limit");

  // no result without an outstanding pixel, at most two outstanding
  a_pending: assert property (@(posedge clk) disable iff (rst)
    (res_valid |-> pending != 2'd0) and (pending <= 2'd2))
    else $error("result without outstanding pixel");

endmodule

bind mandelbrot_escape_time met_checker u_met_checker (
  .clk             (clk),
  .rst             (rst),
  .pix_valid       (pix.valid),
  .pix_ready       (pix.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .out_x           (res.out_x),
  .out_y           (res.out_y),
  .iteration_count (res.iteration_count),
  .cfg_valid       (cfg.valid),
  .cfg_ready       (cfg.ready),
  .cfg_index       (cfg.index),
  .cfg_data        (cfg.data)
);

[tb/mandelbrot_escape_time_test.sv]
// mandelbrot_escape_time_test: self-checking bench for the escape-time engine.
// Drives pixel beats and register writes, predicts each iteration count in Q4.28.
// Depends on met_pkg, met_ifs and the mandelbrot_escape_time RTL.
module mandelbrot_escape_time_test;
  timeunit 1ns;
  timeprecision 1ps;

  // write to an index that holds no register, ignored by the engine
  localparam logic [met_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
  // longest run with no beat at all, long enough for one pixel at the top limit
  localparam int QUIET_LIMIT = 40000;
  // 4.0 in Q8.56
  localparam longint unsigned ESCAPE_MAG = 64'h0400_0000_0000_0000;

  typedef struct {
    logic [met_pkg::PIX_W-1:0] x;
    logic [met_pkg::PIX_W-1:0] y;
    logic [met_pkg::CNT_W-1:0] count;
  } pixel_result_t;

  logic clk;
  logic rst;

  met_pix_if pix_bus ();
  met_res_if res_bus ();
  met_cfg_if cfg_bus ();

  mandelbrot_escape_time dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  met_pkg::met_cfg_t view;
  pixel_result_t     pending_results[$];
  pixel_result_t     checked_beat;
  bit                gaps_on;
  int                mismatches;
  int                pixels_sent;
  int                views_loaded;
  int                escaped;
  int                limit_hits;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // clamp a wide value to the Q4.28 range
  function automatic longint clamp_q(input longint v);
    if (v > longint'(met_pkg::Q_MAX)) begin
      return longint'(met_pkg::Q_MAX);
    end else if (v < longint'(met_pkg::Q_MIN)) begin
      return longint'(met_pkg::Q_MIN);
    end
    return v;
  endfunction

  // map the pixel to c and count z = z*z + c steps until escape or the limit
  function automatic logic [met_pkg::CNT_W-1:0] escape_count(
      input logic [met_pkg::PIX_W-1:0] px,
      input logic [met_pkg::PIX_W-1:0] py,
      input met_pkg::met_cfg_t         v);
    longint          c_re;
    longint          c_im;
    longint          re;
    longint          im;
    longint          re2;
    longint          im2;
    longint          re_next;
    longint unsigned mag;
    int unsigned     n;
    bit              done;
    c_re = clamp_q((longint'(px) - met_pkg::IMAGE_WIDTH / 2) * longint'(v.step_re)
                   + longint'($signed(v.center_re)));
    c_im = clamp_q((longint'(py) - met_pkg::IMAGE_HEIGHT / 2) * longint'(v.step_im)
                   + longint'($signed(v.center_im)));
    re = 0;
    im = 0;
    n = 0;
    done = 1'b0;
    while (!done) begin
      re2 = re * re;
      im2 = im * im;
      mag = $unsigned(re2) + $unsigned(im2);
      if (mag >= ESCAPE_MAG || n >= v.max_iterations) begin
        done = 1'b1;
      end else begin
        // flooring shifts narrow Q8.56 back to Q4.28, doubling folded into the shift
        re_next = clamp_q(((re2 - im2) >>> met_pkg::FRAC_BITS) + c_re);
        im = clamp_q(((re * im) >>> (met_pkg::FRAC_BITS - 1)) + c_im);
        re = re_next;
        n++;
      end
    end
    return n[met_pkg::CNT_W-1:0];
  endfunction

  // result sink with random stall bursts
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
    end
  end

  // predict on each pixel beat, compare on each result beat
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_bus.valid && pix_bus.ready) begin
        checked_beat.x = pix_bus.pixel_x;
        checked_beat.y = pix_bus.pixel_y;
        checked_beat.count = escape_count(pix_bus.pixel_x, pix_bus.pixel_y, view);
        if (checked_beat.count < view.max_iterations) begin
          escaped++;
        end else begin
          limit_hits++;
        end
        pending_results.push_back(checked_beat);
      end
      if (res_bus.valid && res_bus.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with none pending: out_x %0d out_y %0d count %0d",
                 res_bus.out_x, res_bus.out_y, res_bus.iteration_count);
          mismatches++;
        end else begin
          checked_beat = pending_results.pop_front();
          if (res_bus.out_x !== checked_beat.x) begin
            $error("out_x: expected %0d, got %0d", checked_beat.x, res_bus.out_x);
            mismatches++;
          end
          if (res_bus.out_y !== checked_beat.y) begin
            $error("out_y: expected %0d, got %0d", checked_beat.y, res_bus.out_y);
            mismatches++;
          end
          if (res_bus.iteration_count !== checked_beat.count) begin
            $error("iteration_count: expected %0d, got %0d (pixel %0d,%0d)",
                   checked_beat.count, res_bus.iteration_count,
                   checked_beat.x, checked_beat.y);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)
          || (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no beat for %0d cycles, %0d results pending",
             QUIET_LIMIT, pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // one register write beat; valid stays up for a following write
  task automatic write_word(input logic [met_pkg::CFG_IDX_W-1:0] idx,
                            input logic [met_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    case (idx)
      met_pkg::CFG_STEP_RE:   view.step_re = data[met_pkg::STEP_W-1:0];
      met_pkg::CFG_STEP_IM:   view.step_im = data[met_pkg::STEP_W-1:0];
      met_pkg::CFG_CENTER_RE: view.center_re = data;
      met_pkg::CFG_CENTER_IM: view.center_im = data;
      met_pkg::CFG_MAX_ITER:  view.max_iterations = data[met_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  // program all five registers, only while the engine is idle
  task automatic load_view(input logic [31:0] sre, input logic [31:0] sim,
                           input logic [31:0] cre, input logic [31:0] cim,
                           input logic [31:0] lim);
    write_word(met_pkg::CFG_STEP_RE, sre);
    write_word(met_pkg::CFG_STEP_IM, sim);
    write_word(met_pkg::CFG_CENTER_RE, cre);
    write_word(met_pkg::CFG_CENTER_IM, cim);
    write_word(met_pkg::CFG_MAX_ITER, lim);
    cfg_bus.valid <= 1'b0;
    views_loaded++;
  endtask

  // one pixel beat, with an optional gap ahead of it
  task automatic send_pixel(input logic [met_pkg::PIX_W-1:0] x,
                            input logic [met_pkg::PIX_W-1:0] y);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      pix_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    pix_bus.valid   <= 1'b1;
    pix_bus.pixel_x <= x;
    pix_bus.pixel_y <= y;
    do @(posedge clk); while (!(pix_bus.valid && pix_bus.ready));
    pixels_sent++;
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    pix_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // step word: zero, full scale, raw random or a usual zoom; top bit is don't-care
  function automatic logic [31:0] pick_step();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0:       w = 32'h0;
      1:       w = 32'h7fff_ffff;
      2:       w = $urandom;
      default: w = $urandom_range(32'h0002_0000, 32'h0040_0000);
    endcase
    w[31] = $urandom_range(0, 1);
    return w;
  endfunction

  // center word: extremes, raw random or within the interesting +/-2 region
  function automatic logic [31:0] pick_center();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    endcase
  endfunction

  // limit word: low bits are the limit, upper bits random noise
  function automatic logic [31:0] pick_limit();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0:       w[met_pkg::CNT_W-1:0] = '0;
      1:       w[met_pkg::CNT_W-1:0] = 12'd1;
      default: w[met_pkg::CNT_W-1:0] = $urandom_range(2, 120);
    endcase
    return w;
  endfunction

  // pixels under the register values left by reset
  task automatic test_reset_defaults();
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd0, 9'd256);
    send_pixel(9'd511, 9'd0);
    drain();
  endtask

  // a zero limit gives a zero count everywhere
  task automatic test_zero_limit();
    load_view(32'h001e_0000, 32'h0014_0000, 32'h0, 32'h0, 32'hffff_f000);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd511, 9'd0);
    drain();
  endtask

  // mapping that overflows Q4.28 clamps at both ends
  task automatic test_mapping_saturation();
    load_view(32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'd50);
    send_pixel(9'd0, 9'd511);
    send_pixel(9'd511, 9'd0);
    send_pixel(9'd256, 9'd256);
    drain();
  endtask

  // |z|^2 exactly 4 escapes; negative products exercise the flooring shifts
  task automatic test_escape_boundary();
    load_view(32'h0, 32'h0, 32'he000_0000, 32'h0, 32'd50);
    send_pixel(9'd100, 9'd400);
    drain();
    load_view(32'h0, 32'h0, 32'h0, 32'h2000_0000, 32'd50);
    send_pixel(9'd300, 9'd7);
    drain();
    load_view(32'h0000_8000, 32'h0000_8000, 32'hfe66_6666, 32'hf599_999a, 32'd200);
    send_pixel(9'd255, 9'd257);
    send_pixel(9'd0, 9'd511);
    send_pixel(9'd511, 9'd0);
    drain();
  endtask

  // the top limit with points that never escape
  task automatic test_iteration_ceiling();
    load_view(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0fff);
    send_pixel(9'd256, 9'd256);
    drain();
    load_view(32'h0, 32'h0, 32'hf000_0000, 32'h0, 32'h0000_0fff);
    send_pixel(9'd511, 9'd511);
    drain();
    load_view(32'h0, 32'h0, 32'h0400_0000, 32'h0, 32'h0000_0fff);
    send_pixel(9'd0, 9'd0);
    drain();
  endtask

  // a write to an empty index leaves the registers alone
  task automatic test_unused_register();
    write_word(CFG_NO_REG, $urandom);
    cfg_bus.valid <= 1'b0;
    send_pixel(9'd128, 9'd384);
    send_pixel(9'd384, 9'd128);
    drain();
  endtask

  // random views, each with a batch of random pixels
  task automatic test_random_views();
    int phase;
    int k;
    for (phase = 0; phase < 10; phase++) begin
      gaps_on = (phase != 4);
      load_view(pick_step(), pick_step(), pick_center(), pick_center(), pick_limit());
      for (k = 0; k < 120; k++) begin
        send_pixel($urandom_range(0, 511), $urandom_range(0, 511));
      end
      drain();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_stream();
    int k;
    gaps_on = 1'b0;
    load_view(pick_step(), pick_step(), pick_center(), pick_center(), pick_limit());
    for (k = 0; k < 150; k++) begin
      send_pixel($urandom_range(0, 511), $urandom_range(0, 511));
    end
    drain();
  endtask

  // sequence
  initial begin
    rst             <= 1'b1;
    pix_bus.valid   <= 1'b0;
    pix_bus.pixel_x <= '0;
    pix_bus.pixel_y <= '0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= met_pkg::CFG_STEP_RE;
    cfg_bus.data    <= '0;
    gaps_on = 1'b1;
    mismatches = 0;
    pixels_sent = 0;
    views_loaded = 0;
    escaped = 0;
    limit_hits = 0;
    view.step_re = met_pkg::STEP_RE_RST;
    view.step_im = met_pkg::STEP_IM_RST;
    view.center_re = '0;
    view.center_im = '0;
    view.max_iterations = met_pkg::MAX_ITER_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_zero_limit();
    test_mapping_saturation();
    test_escape_boundary();
    test_iteration_ceiling();
    test_unused_register();
    test_random_views();
    test_steady_stream();

    // quiet tail so a stray result beat would still be caught
    repeat (40) @(posedge clk);
    $display("checked %0d pixels across %0d register settings", pixels_sent, views_loaded);
    $display("%0d escaped before the limit, %0d ran to the limit", escaped, limit_hits);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
